// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FFA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FFA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Pool geometry, item types, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int POOL_BYTES   = 1024;
   localparam int HEADER_BYTES = 16;
   localparam int ALIGN_BYTES  = 8;
   localparam int GRANULES     = POOL_BYTES / ALIGN_BYTES;
   localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
   localparam int HDR_GRANS    = HEADER_BYTES / ALIGN_BYTES;

   localparam int GRAN_W = $clog2(GRANULES);
   localparam int LINK_W = 8;
   localparam int REQ_W  = 16;
   localparam int NEED_W = REQ_W + 1;
   localparam int OFS_W  = 10;
   localparam int SIZE_W = 11;
   localparam int SUM_W  = 32;
   // new header granule: cur + header granules + need granules
   localparam int NG_W   = SIZE_W - ALIGN_SHIFT + 2;

   localparam logic [LINK_W-1:0] LINK_END  = '1;
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(POOL_BYTES - HEADER_BYTES);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_SIZE = 2'd1,
      STATUS_NO_FIT    = 2'd2,
      STATUS_NULL_FREE = 2'd3
   } status_type;

   typedef enum logic {
      ACTION_ALLOC = 1'b0,
      ACTION_FREE  = 1'b1
   } action_type;

   typedef struct packed {
      action_type         action;
      logic [REQ_W-1:0]   req_size;
      logic [OFS_W-1:0]   free_offset;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [OFS_W-1:0]   result_offset;
      logic [SIZE_W-1:0]  granted_bytes;
      logic [SUM_W-1:0]   allocated_total;
      logic [SUM_W-1:0]   freed_total;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       wr_tail;
      logic       wr_split_head;
      logic       wr_unlink;
      logic       wr_free;
      logic       rsp_fire;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic req_zero;
      logic free_bad;
      logic list_empty;
      logic fit;
      logic split;
      logic at_end;
      logic last_step;
   } stat_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

endpackage

// File: hdl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences request checks, the first-fit walk, header writes and the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_CHECK      = 7'b0000010,
      ST_WALK       = 7'b0000100,
      ST_SPLIT_TAIL = 7'b0001000,
      ST_SPLIT_HEAD = 7'b0010000,
      ST_UNLINK     = 7'b0100000,
      ST_FREE_PUSH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = ffa_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_free) begin
               if (stat.free_bad) begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = ffa_pkg::STATUS_NULL_FREE;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_FREE_PUSH;
               end
            end else if (stat.req_zero) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ffa_pkg::STATUS_ZERO_SIZE;
               state_in       = ST_IDLE;
            end else if (stat.list_empty) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ffa_pkg::STATUS_NO_FIT;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (stat.fit) begin
               state_in = stat.split ? ST_SPLIT_TAIL : ST_UNLINK;
            end else if (stat.at_end || stat.last_step) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ffa_pkg::STATUS_NO_FIT;
               state_in       = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_SPLIT_TAIL: begin
            cmd.wr_tail = 1'b1;
            state_in    = ST_SPLIT_HEAD;
         end
         ST_SPLIT_HEAD: begin
            cmd.wr_split_head = 1'b1;
            cmd.rsp_fire      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_UNLINK: begin
            cmd.wr_unlink = 1'b1;
            cmd.rsp_fire  = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FREE_PUSH: begin
            cmd.wr_free  = 1'b1;
            cmd.rsp_fire = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `FFA_ASSERT_NEXT(a_rsp_ends_item, clock, reset, cmd.rsp_fire, state_ff == ST_IDLE, "item not closed after result")
   `FFA_ASSERT_NEXT(a_load_to_check, clock, reset, cmd.load, busy && state_ff == ST_CHECK, "load did not enter check")
   `FFA_ASSERT_IMPL(a_one_write, clock, reset, 1'b1, $onehot0({cmd.wr_tail, cmd.wr_split_head, cmd.wr_unlink, cmd.wr_free}), "two header writes at once")

endmodule

// File: hdl/ffa_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Header stores, list head, walk registers, saturating totals, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ffa_pkg::req_type  req_data,
   input  ffa_pkg::cmd_type  cmd,
   output ffa_pkg::stat_type stat,
   output logic              rsp_valid,
   output ffa_pkg::rsp_type  rsp_data
);

   localparam int GW = ffa_pkg::GRAN_W;
   localparam int LW = ffa_pkg::LINK_W;
   localparam int SW = ffa_pkg::SIZE_W;
   localparam int NW = ffa_pkg::NEED_W;
   localparam int OW = ffa_pkg::OFS_W;
   localparam int UW = ffa_pkg::SUM_W;

   // header stores, one entry per granule
   logic [SW-1:0] size_mem [ffa_pkg::GRANULES];
   logic [LW-1:0] next_mem [ffa_pkg::GRANULES];

   logic [SW-1:0] size_rd_ff;
   logic [LW-1:0] next_rd_ff;
   logic          size_rd_init_ff, next_rd_init_ff;
   logic          size0_init_ff, size0_init_in;
   logic          next0_init_ff, next0_init_in;

   ffa_pkg::action_type action_ff;
   logic [NW-1:0] need_ff;
   logic          req_zero_ff, free_bad_ff;
   logic [LW-1:0] cur_ff, cur_in;
   logic [GW-1:0] prev_ff, prev_in;
   logic          has_prev_ff, has_prev_in;
   logic [GW-1:0] steps_ff, steps_in;
   logic [LW-1:0] head_ff, head_in;
   logic [UW-1:0] alloc_sum_ff, alloc_sum_in;
   logic [UW-1:0] free_sum_ff, free_sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ffa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [SW-1:0] csize;
   logic [LW-1:0] cnext;
   logic [GW-1:0] cur_g;
   logic [NW-1:0] need_in;
   logic [OW-1:0] gofs;
   logic [NW:0]   need_hdr;
   logic [ffa_pkg::NG_W-1:0] ng_sum;
   logic [GW-1:0] ng;
   logic [SW-1:0] rem_size;
   logic [GW-1:0] rd_addr;
   logic          size_we, next_we;
   logic [GW-1:0] size_waddr, next_waddr;
   logic [SW-1:0] size_wdata;
   logic [LW-1:0] next_wdata;
   logic          link_wr;

   // granule 0 keeps its reset header until first written
   assign csize = size_rd_init_ff ? ffa_pkg::INIT_SIZE : size_rd_ff;
   assign cnext = next_rd_init_ff ? ffa_pkg::LINK_END : next_rd_ff;
   assign cur_g = cur_ff[GW-1:0];

   assign need_in = (NW'(req_data.req_size) + NW'(ffa_pkg::ALIGN_BYTES - 1))
                    & ~NW'(ffa_pkg::ALIGN_BYTES - 1);
   assign gofs    = req_data.free_offset - OW'(ffa_pkg::HEADER_BYTES);

   assign need_hdr = {1'b0, need_ff} + (NW + 1)'(ffa_pkg::HEADER_BYTES);
   assign ng_sum   = ffa_pkg::NG_W'(cur_g) + ffa_pkg::NG_W'(ffa_pkg::HDR_GRANS)
                   + ffa_pkg::NG_W'(need_ff[SW-1:ffa_pkg::ALIGN_SHIFT]);
   assign ng       = ng_sum[GW-1:0];
   assign rem_size = csize - need_ff[SW-1:0] - SW'(ffa_pkg::HEADER_BYTES);

   always_comb begin
      stat.is_free    = (action_ff == ffa_pkg::ACTION_FREE);
      stat.req_zero   = req_zero_ff;
      stat.free_bad   = free_bad_ff;
      stat.list_empty = (head_ff >= LW'(ffa_pkg::GRANULES));
      stat.fit        = (NW'(csize) >= need_ff);
      stat.split      = ((NW + 1)'(csize) > need_hdr)
                        && (ng_sum < ffa_pkg::NG_W'(ffa_pkg::GRANULES));
      stat.at_end     = (cnext >= LW'(ffa_pkg::GRANULES));
      stat.last_step  = (steps_ff == GW'(ffa_pkg::GRANULES - 1));
   end

   // write ports: one per store
   assign link_wr    = cmd.wr_split_head || cmd.wr_unlink;
   assign size_we    = cmd.wr_tail || cmd.wr_split_head;
   assign size_waddr = cmd.wr_tail ? ng : cur_g;
   assign size_wdata = cmd.wr_tail ? rem_size : need_ff[SW-1:0];

   always_comb begin
      next_we    = 1'b0;
      next_waddr = prev_ff;
      next_wdata = cnext;
      priority if (cmd.wr_tail) begin
         next_we    = 1'b1;
         next_waddr = ng;
         next_wdata = cnext;
      end else if (cmd.wr_free) begin
         next_we    = 1'b1;
         next_waddr = cur_g;
         next_wdata = head_ff;
      end else if (link_wr && has_prev_ff) begin
         next_we    = 1'b1;
         next_waddr = prev_ff;
         next_wdata = cmd.wr_split_head ? LW'(ng) : cnext;
      end
   end

   assign rd_addr = cmd.step ? cnext[GW-1:0] : cur_g;

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      size_rd_ff      <= size_mem[rd_addr];
      next_rd_ff      <= next_mem[rd_addr];
      size_rd_init_ff <= size0_init_ff && (rd_addr == '0);
      next_rd_init_ff <= next0_init_ff && (rd_addr == '0);
   end

   always_comb begin
      size0_init_in = size0_init_ff && !(size_we && size_waddr == '0);
      next0_init_in = next0_init_ff && !(next_we && next_waddr == '0);

      cur_in      = cur_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      steps_in    = steps_ff;
      if (cmd.load) begin
         cur_in      = (req_data.action == ffa_pkg::ACTION_FREE)
                       ? LW'(gofs[OW-1:ffa_pkg::ALIGN_SHIFT]) : head_ff;
         has_prev_in = 1'b0;
         steps_in    = '0;
      end else if (cmd.step) begin
         prev_in     = cur_g;
         has_prev_in = 1'b1;
         cur_in      = cnext;
         steps_in    = steps_ff + GW'(1);
      end

      head_in = head_ff;
      if (cmd.wr_free) begin
         head_in = LW'(cur_g);
      end else if (link_wr && !has_prev_ff) begin
         head_in = cmd.wr_split_head ? LW'(ng) : cnext;
      end

      alloc_sum_in = alloc_sum_ff;
      if (link_wr) begin
         alloc_sum_in = ffa_pkg::sat_add(alloc_sum_ff, UW'(need_ff));
      end
      free_sum_in = free_sum_ff;
      if (cmd.wr_free) begin
         free_sum_in = ffa_pkg::sat_add(free_sum_ff, UW'(csize));
      end

      rsp_valid_in                = cmd.rsp_fire;
      rsp_data_in                 = rsp_data_ff;
      if (cmd.rsp_fire) begin
         rsp_data_in.status          = cmd.rsp_status;
         rsp_data_in.result_offset   = '0;
         rsp_data_in.granted_bytes   = '0;
         rsp_data_in.allocated_total = alloc_sum_in;
         rsp_data_in.freed_total     = free_sum_in;
         if (cmd.rsp_status == ffa_pkg::STATUS_OK) begin
            if (action_ff == ffa_pkg::ACTION_FREE) begin
               rsp_data_in.granted_bytes = csize;
            end else begin
               rsp_data_in.granted_bytes = need_ff[SW-1:0];
               rsp_data_in.result_offset = OW'({cur_g, {ffa_pkg::ALIGN_SHIFT{1'b0}}})
                                         + OW'(ffa_pkg::HEADER_BYTES);
            end
         end
      end
   end

   // request capture, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_data.action;
         need_ff     <= need_in;
         req_zero_ff <= (req_data.req_size == '0);
         free_bad_ff <= (req_data.free_offset < OW'(ffa_pkg::HEADER_BYTES))
                        || ({1'b0, req_data.free_offset} >= (OW + 1)'(ffa_pkg::POOL_BYTES));
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      has_prev_ff <= has_prev_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size0_init_ff <= 1'b1;
         next0_init_ff <= 1'b1;
         head_ff       <= '0;
         alloc_sum_ff  <= '0;
         free_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size0_init_ff <= size0_init_in;
         next0_init_ff <= next0_init_in;
         head_ff       <= head_in;
         alloc_sum_ff  <= alloc_sum_in;
         free_sum_ff   <= free_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FFA_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held two cycles")
   `FFA_ASSERT_IMPL(a_tail_above_cur, clock, reset, cmd.wr_tail, ng_sum > ffa_pkg::NG_W'(cur_g), "split header not above block")
   `FFA_ASSERT_IMPL(a_grant_fits, clock, reset, link_wr, stat.fit, "block granted without fit")

endmodule

// File: hdl/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// First-fit free-list allocator
// Byte pool managed as a singly linked list of headers, first-fit allocate
// with split, free by push to list head, saturating byte totals.
// ----------------------------------------------------------------------------
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start && !busy
//   result    rsp_valid, rsp_data        one-cycle strobe, never stalled
//
// Zero-size, null free or empty list: the result is raised from the check state.
// Free: check, then push to the list head. Allocate: check, then the walk, then
// an unlink, or a tail and a head write on a split; with no fit the walk ends the
// item. The walk reads one header per cycle and stops after 128 blocks.
// busy falls as the result strobe rises; the next item can be taken at the
// edge that ends the strobe.
// Reset leaves the pool as one free block at granule 0; no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   output ffa_pkg::rsp_type rsp_data
);

   ffa_pkg::cmd_type  cmd;
   ffa_pkg::stat_type stat;

   ffa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
